/* sv/losa_pkg.sv */
package losa_pkg;

  localparam int ANGLE_FRAC_BITS   = 13;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;
  localparam int Q30_SHIFT         = 30 - ANGLE_FRAC_BITS;
  localparam int SQRT_STAGES       = 32;

  typedef logic signed [31:0] elem_t;   // matrix element, Q30
  typedef logic signed [63:0] prod_t;
  typedef logic signed [65:0] acc_t;
  typedef logic signed [35:0] ang_t;    // angle, Q30
  typedef logic signed [33:0] opnd_t;   // atan2 operand
  typedef logic signed [37:0] vec_t;    // vectoring datapath
  typedef logic signed [33:0] rot_t;    // rotation datapath
  typedef elem_t [2:0][2:0] mat_t;

  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH      = 3'd0,
    CFG_IMAGE_HEIGHT     = 3'd1,
    CFG_FOCAL_HORIZONTAL = 3'd2,
    CFG_FOCAL_VERTICAL   = 3'd3,
    CFG_MOUNT_PITCH      = 3'd4
  } cfg_reg_t;

  localparam ang_t Q30_PI      = 36'sd3373259426;
  localparam ang_t Q30_HALF_PI = 36'sd1686629713;
  localparam ang_t Q30_TWO_PI  = 36'sd6746518852;
  localparam rot_t Q30_GAIN    = 34'sd652032874;

  localparam ang_t ATAN_TAB [ATAN_LEN] = '{
    36'sd843314857, 36'sd497837830, 36'sd263043837, 36'sd133525159, 36'sd67021687,
    36'sd33543516, 36'sd16775851, 36'sd8388437, 36'sd4194283, 36'sd2097149,
    36'sd1048576, 36'sd524288, 36'sd262144, 36'sd131072, 36'sd65536, 36'sd32768,
    36'sd16384, 36'sd8192, 36'sd4096, 36'sd2048, 36'sd1024, 36'sd512, 36'sd256,
    36'sd128
  };

  localparam ang_t OUT_HALF    = ang_t'(64'sd1 <<< (Q30_SHIFT - 1));
  localparam ang_t LIM_PI      = (Q30_PI + OUT_HALF) >>> Q30_SHIFT;
  localparam ang_t LIM_HALF_PI = (Q30_HALF_PI + OUT_HALF) >>> Q30_SHIFT;
  localparam ang_t WMAX16      = 36'sd32767;
  localparam ang_t WMAX15      = 36'sd16383;

  function automatic int sincos_latency(int stages);
    return stages + 3;
  endfunction

  function automatic int atan2_latency(int stages);
    return stages + 5;
  endfunction

  function automatic int euler_latency(int stages);
    return stages + 7;
  endfunction

  function automatic prod_t mul(elem_t a, elem_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  // Sum of up to three products, rounded half up back to Q30.
  function automatic elem_t rnd_sum3(prod_t a, prod_t b, prod_t c);
    acc_t s;
    s = acc_t'(a) + acc_t'(b) + acc_t'(c) + (acc_t'(1) <<< 29);
    s = s >>> 30;
    return elem_t'(s);
  endfunction

  function automatic ang_t to_q30(logic signed [15:0] a);
    return ang_t'(a) <<< Q30_SHIFT;
  endfunction

  function automatic ang_t sat_angle(ang_t z, ang_t lim, ang_t wmax);
    ang_t q;
    q = (z + OUT_HALF) >>> Q30_SHIFT;
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    if (q > wmax) q = wmax;
    if (q < -wmax - 36'sd1) q = -wmax - 36'sd1;
    return q;
  endfunction

endpackage

/* sv/losa_sincos.sv */
module losa_sincos #(
  parameter int CORDIC_STAGES = losa_pkg::CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 ce,
  input  losa_pkg::ang_t       angle,
  output losa_pkg::elem_t      sin_out,
  output losa_pkg::elem_t      cos_out
);

  losa_pkg::ang_t r1;
  losa_pkg::ang_t zr [0:CORDIC_STAGES];
  losa_pkg::rot_t xs [0:CORDIC_STAGES];
  losa_pkg::rot_t ys [0:CORDIC_STAGES];
  logic           fl [0:CORDIC_STAGES];

  // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
  always_ff @(posedge clk) begin
    if (ce) begin
      if (angle > losa_pkg::Q30_PI) begin
        r1 <= angle - losa_pkg::Q30_TWO_PI;
      end else if (angle < -losa_pkg::Q30_PI) begin
        r1 <= angle + losa_pkg::Q30_TWO_PI;
      end else begin
        r1 <= angle;
      end
      if (r1 > losa_pkg::Q30_HALF_PI) begin
        zr[0] <= r1 - losa_pkg::Q30_PI;
        fl[0] <= 1'b1;
      end else if (r1 < -losa_pkg::Q30_HALF_PI) begin
        zr[0] <= r1 + losa_pkg::Q30_PI;
        fl[0] <= 1'b1;
      end else begin
        zr[0] <= r1;
        fl[0] <= 1'b0;
      end
      xs[0] <= losa_pkg::Q30_GAIN;
      ys[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (ce) begin
        fl[i+1] <= fl[i];
        if (zr[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zr[i+1] <= zr[i] - losa_pkg::ATAN_TAB[i];
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zr[i+1] <= zr[i] + losa_pkg::ATAN_TAB[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cos_out <= fl[CORDIC_STAGES] ? losa_pkg::elem_t'(-xs[CORDIC_STAGES])
                                   : losa_pkg::elem_t'(xs[CORDIC_STAGES]);
      sin_out <= fl[CORDIC_STAGES] ? losa_pkg::elem_t'(-ys[CORDIC_STAGES])
                                   : losa_pkg::elem_t'(ys[CORDIC_STAGES]);
    end
  end

endmodule

/* sv/losa_atan2.sv */
module losa_atan2 #(
  parameter int CORDIC_STAGES = losa_pkg::CORDIC_STAGES_DEF
) (
  input  logic            clk,
  input  logic            ce,
  input  losa_pkg::opnd_t y_in,
  input  losa_pkg::opnd_t x_in,
  output losa_pkg::ang_t  z_out
);

  losa_pkg::vec_t a_x, a_y, b_x, b_y;
  losa_pkg::ang_t a_off, b_off, c_z;
  logic           a_zero, b_zero, c_zero;
  logic [4:0]     b_s, s_sel;
  logic [37:0]    u;

  losa_pkg::vec_t xs [0:CORDIC_STAGES];
  losa_pkg::vec_t ys [0:CORDIC_STAGES];
  losa_pkg::ang_t zs [0:CORDIC_STAGES];
  losa_pkg::ang_t off_d [0:CORDIC_STAGES];
  logic           zero_d [0:CORDIC_STAGES];

  // move a left-half operand to the right half with an offset of pi
  always_ff @(posedge clk) begin
    if (ce) begin
      a_zero <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        a_x   <= -losa_pkg::vec_t'(x_in);
        a_y   <= -losa_pkg::vec_t'(y_in);
        a_off <= (y_in >= 0) ? losa_pkg::Q30_PI : -losa_pkg::Q30_PI;
      end else begin
        a_x   <= losa_pkg::vec_t'(x_in);
        a_y   <= losa_pkg::vec_t'(y_in);
        a_off <= '0;
      end
    end
  end

  // shift count that brings the larger magnitude up to 2^29
  always_comb begin
    u = a_x | ((a_y < 0) ? -a_y : a_y);
    s_sel = '0;
    if (u < 38'd536870912) begin
      for (int i = 0; i < 29; i++) begin
        if (u[i]) s_sel = 5'(29 - i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      b_x    <= a_x;
      b_y    <= a_y;
      b_s    <= s_sel;
      b_off  <= a_off;
      b_zero <= a_zero;
      xs[0]     <= b_x <<< b_s;
      ys[0]     <= b_y <<< b_s;
      zs[0]     <= '0;
      off_d[0]  <= b_off;
      zero_d[0] <= b_zero;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (ce) begin
        off_d[i+1]  <= off_d[i];
        zero_d[i+1] <= zero_d[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + losa_pkg::ATAN_TAB[i];
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - losa_pkg::ATAN_TAB[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c_z    <= zs[CORDIC_STAGES] + off_d[CORDIC_STAGES];
      c_zero <= zero_d[CORDIC_STAGES];
      if (c_zero) begin
        z_out <= '0;
      end else if (c_z > losa_pkg::Q30_PI) begin
        z_out <= c_z - losa_pkg::Q30_TWO_PI;
      end else if (c_z < -losa_pkg::Q30_PI) begin
        z_out <= c_z + losa_pkg::Q30_TWO_PI;
      end else begin
        z_out <= c_z;
      end
    end
  end

endmodule

/* sv/losa_euler.sv */
module losa_euler #(
  parameter int CORDIC_STAGES = losa_pkg::CORDIC_STAGES_DEF
) (
  input  logic            clk,
  input  logic            ce,
  input  losa_pkg::ang_t  roll,
  input  losa_pkg::ang_t  pitch,
  input  losa_pkg::ang_t  yaw,
  output losa_pkg::mat_t  rot
);

  losa_pkg::elem_t sr, cr, sp, cp, sy, cy;
  losa_pkg::prod_t p_cycp, p_cysp, p_sycp, p_sysp;
  losa_pkg::elem_t sy1, cy1, sp1, cp1, sr1, cr1;
  losa_pkg::elem_t t00, t01, t02, t10, t11, t12, t20, cp2, sr2, cr2;
  losa_pkg::prod_t a1, a2, b1, b2, c1, c2, d1, d2, e1, f1;
  losa_pkg::elem_t t00_3, t10_3, t20_3;

  losa_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .ce(ce), .angle(roll), .sin_out(sr), .cos_out(cr)
  );
  losa_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .ce(ce), .angle(pitch), .sin_out(sp), .cos_out(cp)
  );
  losa_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .ce(ce), .angle(yaw), .sin_out(sy), .cos_out(cy)
  );

  // Rz*Ry first, then times Rx; zero and unit terms drop out exactly
  always_ff @(posedge clk) begin
    if (ce) begin
      p_cycp <= losa_pkg::mul(cy, cp);
      p_cysp <= losa_pkg::mul(cy, sp);
      p_sycp <= losa_pkg::mul(sy, cp);
      p_sysp <= losa_pkg::mul(sy, sp);
      sy1 <= sy;
      cy1 <= cy;
      sp1 <= sp;
      cp1 <= cp;
      sr1 <= sr;
      cr1 <= cr;

      t00 <= losa_pkg::rnd_sum3(p_cycp, '0, '0);
      t02 <= losa_pkg::rnd_sum3(p_cysp, '0, '0);
      t10 <= losa_pkg::rnd_sum3(p_sycp, '0, '0);
      t12 <= losa_pkg::rnd_sum3(p_sysp, '0, '0);
      t01 <= -sy1;
      t11 <= cy1;
      t20 <= -sp1;
      cp2 <= cp1;
      sr2 <= sr1;
      cr2 <= cr1;

      a1 <= losa_pkg::mul(t01, cr2);
      a2 <= losa_pkg::mul(t02, sr2);
      b1 <= losa_pkg::mul(t01, sr2);
      b2 <= losa_pkg::mul(t02, cr2);
      c1 <= losa_pkg::mul(t11, cr2);
      c2 <= losa_pkg::mul(t12, sr2);
      d1 <= losa_pkg::mul(t11, sr2);
      d2 <= losa_pkg::mul(t12, cr2);
      e1 <= losa_pkg::mul(cp2, sr2);
      f1 <= losa_pkg::mul(cp2, cr2);
      t00_3 <= t00;
      t10_3 <= t10;
      t20_3 <= t20;

      rot[0][0] <= t00_3;
      rot[0][1] <= losa_pkg::rnd_sum3(a1, a2, '0);
      rot[0][2] <= losa_pkg::rnd_sum3(-b1, b2, '0);
      rot[1][0] <= t10_3;
      rot[1][1] <= losa_pkg::rnd_sum3(c1, c2, '0);
      rot[1][2] <= losa_pkg::rnd_sum3(-d1, d2, '0);
      rot[2][0] <= t20_3;
      rot[2][1] <= losa_pkg::rnd_sum3(e1, '0, '0);
      rot[2][2] <= losa_pkg::rnd_sum3(f1, '0, '0);
    end
  end

endmodule

/* sv/line_of_sight_angle_calc.sv */
// Line-of-sight angle calculator.
// Input stream (s_*): one item per target detection, carrying the pixel
// position in 1/16 pixel units and the vehicle roll, pitch and yaw in Q3.13
// radians. Output stream (m_*): one item per input item, in order, with the
// NED line-of-sight yaw and pitch in Q3.13 radians and the gimbal-lock flag.
// Configuration port (cfg_*): image size, focal lengths and mount pitch; it
// is always ready and is meant to be written while no item is in flight.
// The path runs through two atan2 CORDIC passes, the sine/cosine CORDIC,
// two 3x3 matrix products and a 32-stage square root. One item is accepted
// per cycle while the output is not stalled.
// All stages share one advance enable: when the output holds an item that
// the receiver does not take, the whole pipeline and s_tready hold, and no
// item is lost or repeated. Reset empties the pipeline and loads the
// default configuration (640x480 image, focal 640/480, mount pitch -2145).
module line_of_sight_angle_calc #(
  parameter int CORDIC_STAGES = losa_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // pixel_x, pixel_y, roll_angle, pitch_angle, yaw_angle
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // horizontal_angle, vertical_angle, zero pad
  output logic [31:0] m_tdata,
  // gimbal_lock
  output logic        m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AT_LAT = losa_pkg::atan2_latency(CORDIC_STAGES);
  localparam int EU_LAT = losa_pkg::euler_latency(CORDIC_STAGES);
  localparam int SQ_N   = losa_pkg::SQRT_STAGES;
  localparam int N_V    = 1 + AT_LAT + EU_LAT + 6 + SQ_N + AT_LAT + 1;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } att_t;

  typedef struct packed {
    losa_pkg::opnd_t ny;
    losa_pkg::opnd_t hy;
    losa_pkg::opnd_t hx;
    logic            lock;
  } side_t;

  logic ce;
  logic [N_V-1:0] vld;

  logic [11:0]        image_width, image_height, focal_horizontal, focal_vertical;
  logic signed [15:0] mount_pitch;

  losa_pkg::opnd_t i_dx, i_dy, i_fx, i_fy;
  att_t            i_att;
  att_t            att_dl [0:AT_LAT-1];
  losa_pkg::ang_t  ah, av, zh, zv;
  losa_pkg::mat_t  m_pix, m_mnt, m_att, pd1, pd2, tm;
  losa_pkg::prod_t tp [3][3][3];
  losa_pkg::prod_t rp [3][2][3];
  losa_pkg::elem_t rm [3][2];
  losa_pkg::prod_t s00, s10;
  side_t           x1_side;
  logic            lock_dl [0:AT_LAT-1];

  logic [35:0] sq_rem  [0:SQ_N];
  logic [31:0] sq_root [0:SQ_N];
  logic [63:0] sq_rad  [0:SQ_N];
  side_t       sq_side [0:SQ_N];

  losa_pkg::ang_t h_sat, v_sat;
  logic           lock_x1;

  assign ce        = ~m_tvalid | m_tready;
  assign s_tready  = ce;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = vld[N_V-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= 12'd640;
      image_height     <= 12'd480;
      focal_horizontal <= 12'd640;
      focal_vertical   <= 12'd480;
      mount_pitch      <= -16'sd2145;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        losa_pkg::CFG_IMAGE_WIDTH:      image_width      <= cfg_data[11:0];
        losa_pkg::CFG_IMAGE_HEIGHT:     image_height     <= cfg_data[11:0];
        losa_pkg::CFG_FOCAL_HORIZONTAL: focal_horizontal <= cfg_data[11:0];
        losa_pkg::CFG_FOCAL_VERTICAL:   focal_vertical   <= cfg_data[11:0];
        losa_pkg::CFG_MOUNT_PITCH:      mount_pitch      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[N_V-2:0], s_tvalid};
    end
  end

  // offset from the image centre, focal lengths in 1/16 pixel units
  always_ff @(posedge clk) begin
    if (ce) begin
      i_dx <= losa_pkg::opnd_t'({2'b00, s_tdata[15:0]})
              - losa_pkg::opnd_t'({image_width, 3'b000});
      i_dy <= losa_pkg::opnd_t'({2'b00, s_tdata[31:16]})
              - losa_pkg::opnd_t'({image_height, 3'b000});
      i_fx <= losa_pkg::opnd_t'({focal_horizontal, 4'b0000});
      i_fy <= losa_pkg::opnd_t'({focal_vertical, 4'b0000});
      i_att.roll  <= s_tdata[47:32];
      i_att.pitch <= s_tdata[63:48];
      i_att.yaw   <= s_tdata[79:64];
      att_dl[0]   <= i_att;
      for (int k = 1; k < AT_LAT; k++) att_dl[k] <= att_dl[k-1];
    end
  end

  losa_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_cam_h (
    .clk(clk), .ce(ce), .y_in(i_dx), .x_in(i_fx), .z_out(ah)
  );
  losa_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_cam_v (
    .clk(clk), .ce(ce), .y_in(i_dy), .x_in(i_fy), .z_out(av)
  );

  losa_euler #(.CORDIC_STAGES(CORDIC_STAGES)) u_pix (
    .clk(clk), .ce(ce), .roll('0), .pitch(ah), .yaw(av), .rot(m_pix)
  );
  losa_euler #(.CORDIC_STAGES(CORDIC_STAGES)) u_mnt (
    .clk(clk), .ce(ce), .roll('0), .pitch(losa_pkg::to_q30(mount_pitch)),
    .yaw('0), .rot(m_mnt)
  );
  losa_euler #(.CORDIC_STAGES(CORDIC_STAGES)) u_att (
    .clk(clk), .ce(ce),
    .roll(losa_pkg::to_q30(att_dl[AT_LAT-1].roll)),
    .pitch(losa_pkg::to_q30(att_dl[AT_LAT-1].pitch)),
    .yaw(losa_pkg::to_q30(att_dl[AT_LAT-1].yaw)),
    .rot(m_att)
  );

  // attitude * mount, then times the pixel matrix (first two columns only)
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            tp[i][j][k] <= losa_pkg::mul(m_att[i][k], m_mnt[k][j]);
          end
          tm[i][j] <= losa_pkg::rnd_sum3(tp[i][j][0], tp[i][j][1], tp[i][j][2]);
        end
      end
      pd1 <= m_pix;
      pd2 <= pd1;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 2; j++) begin
          for (int k = 0; k < 3; k++) begin
            rp[i][j][k] <= losa_pkg::mul(tm[i][k], pd2[k][j]);
          end
          rm[i][j] <= losa_pkg::rnd_sum3(rp[i][j][0], rp[i][j][1], rp[i][j][2]);
        end
      end
    end
  end

  assign lock_x1 = (rm[0][0] == '0) && (rm[1][0] == '0);

  always_ff @(posedge clk) begin
    if (ce) begin
      s00 <= losa_pkg::mul(rm[0][0], rm[0][0]);
      s10 <= losa_pkg::mul(rm[1][0], rm[1][0]);
      x1_side.lock <= lock_x1;
      x1_side.ny   <= -losa_pkg::opnd_t'(rm[2][0]);
      x1_side.hy   <= lock_x1 ? -losa_pkg::opnd_t'(rm[0][1]) : losa_pkg::opnd_t'(rm[1][0]);
      x1_side.hx   <= lock_x1 ? losa_pkg::opnd_t'(rm[1][1]) : losa_pkg::opnd_t'(rm[0][0]);
      sq_rad[0]  <= 64'(s00) + 64'(s10);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_side[0] <= x1_side;
    end
  end

  // one root bit per stage, two radicand bits consumed per stage
  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    logic [35:0] rem_sh, trial;
    assign rem_sh = {sq_rem[k][33:0], sq_rad[k][63:62]};
    assign trial  = {2'b00, sq_root[k], 2'b01};
    always_ff @(posedge clk) begin
      if (ce) begin
        sq_rad[k+1]  <= {sq_rad[k][61:0], 2'b00};
        sq_side[k+1] <= sq_side[k];
        if (rem_sh >= trial) begin
          sq_rem[k+1]  <= rem_sh - trial;
          sq_root[k+1] <= {sq_root[k][30:0], 1'b1};
        end else begin
          sq_rem[k+1]  <= rem_sh;
          sq_root[k+1] <= {sq_root[k][30:0], 1'b0};
        end
      end
    end
  end

  losa_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_vert (
    .clk(clk), .ce(ce), .y_in(sq_side[SQ_N].ny),
    .x_in(losa_pkg::opnd_t'({2'b00, sq_root[SQ_N]})), .z_out(zv)
  );
  losa_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_horiz (
    .clk(clk), .ce(ce), .y_in(sq_side[SQ_N].hy), .x_in(sq_side[SQ_N].hx),
    .z_out(zh)
  );

  assign h_sat = losa_pkg::sat_angle(zh, losa_pkg::LIM_PI, losa_pkg::WMAX16);
  assign v_sat = losa_pkg::sat_angle(zv, losa_pkg::LIM_HALF_PI, losa_pkg::WMAX15);

  always_ff @(posedge clk) begin
    if (ce) begin
      lock_dl[0] <= sq_side[SQ_N].lock;
      for (int k = 1; k < AT_LAT; k++) lock_dl[k] <= lock_dl[k-1];
      m_tdata <= {1'b0, v_sat[14:0], h_sat[15:0]};
      m_tuser <= lock_dl[AT_LAT-1];
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int     STAGES       = 16;
  localparam int     SETTLE       = 2 * STAGES + 80;
  localparam int     ANG_MAX      = 25736;
  localparam int     HALF_PI_FIX  = 12868;
  localparam logic [2:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [2:0] CFG_UNUSED_HI = 3'd7;
  localparam longint PI_Q       = 64'sd3373259426;
  localparam longint HALF_PI_Q  = 64'sd1686629713;
  localparam longint TWO_PI_Q   = 64'sd6746518852;
  localparam longint GAIN_Q     = 64'sd652032874;
  localparam longint ONE_Q      = 64'sd1 <<< 30;

  typedef longint rmat_t [3][3];

  typedef struct packed {
    logic [15:0]        pixel_x;
    logic [15:0]        pixel_y;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } target_t;

  typedef struct {
    logic signed [15:0] horiz;
    logic signed [14:0] vert;
    logic               lock;
  } los_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // configuration copy
  longint img_w, img_h, foc_h, foc_v, mnt_pitch;

  los_t expected_los[$];
  int   mismatches = 0;
  int   failures   = 0;
  bit   tx_burst   = 0;
  bit   rx_burst   = 0;
  int   hold_req   = 0;

  line_of_sight_angle_calc uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------- line-of-sight predictor ----------------

  function automatic void los_sincos(input longint a, output longint s, output longint c);
    longint r, x, y, dx, dy;
    bit flip;
    r = a % TWO_PI_Q;
    x = GAIN_Q;
    y = 0;
    flip = 0;
    if (r > PI_Q) r -= TWO_PI_Q;
    if (r < -PI_Q) r += TWO_PI_Q;
    if (r > HALF_PI_Q) begin
      r -= PI_Q;
      flip = 1;
    end else if (r < -HALF_PI_Q) begin
      r += PI_Q;
      flip = 1;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (r >= 0) begin
        x -= dx; y += dy; r -= longint'(losa_pkg::ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; r += longint'(losa_pkg::ATAN_TAB[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint los_atan2(longint y, longint x);
    longint z, off, dx, dy;
    z = 0;
    off = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      off = (y >= 0) ? PI_Q : -PI_Q;
      x = -x;
      y = -y;
    end
    while (x < (64'sd1 <<< 29) && y < (64'sd1 <<< 29) && y > -(64'sd1 <<< 29)) begin
      x *= 2;
      y *= 2;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(losa_pkg::ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(losa_pkg::ATAN_TAB[i]);
      end
    end
    z += off;
    if (z > PI_Q) z -= TWO_PI_Q;
    if (z < -PI_Q) z += TWO_PI_Q;
    return z;
  endfunction

  function automatic rmat_t rot_mul(rmat_t a, rmat_t b);
    rmat_t r;
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
        r[i][j] = (acc + (64'sd1 <<< 29)) >>> 30;
      end
    return r;
  endfunction

  function automatic rmat_t euler_rot(longint roll, longint pitch, longint yaw);
    longint sr, cr, sp, cp, sy, cy;
    rmat_t rx, ry, rz;
    los_sincos(roll, sr, cr);
    los_sincos(pitch, sp, cp);
    los_sincos(yaw, sy, cy);
    rx = '{'{ONE_Q, 0, 0}, '{0, cr, -sr}, '{0, sr, cr}};
    ry = '{'{cp, 0, sp}, '{0, ONE_Q, 0}, '{-sp, 0, cp}};
    rz = '{'{cy, -sy, 0}, '{sy, cy, 0}, '{0, 0, ONE_Q}};
    return rot_mul(rot_mul(rz, ry), rx);
  endfunction

  function automatic longint unsigned isqrt_u64(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint quantize_angle(longint z, longint lim_q, int width);
    longint half, q, lim, wmax;
    half = 64'sd1 <<< (30 - losa_pkg::ANGLE_FRAC_BITS - 1);
    q    = (z + half) >>> (30 - losa_pkg::ANGLE_FRAC_BITS);
    lim  = (lim_q + half) >>> (30 - losa_pkg::ANGLE_FRAC_BITS);
    wmax = (64'sd1 <<< (width - 1)) - 1;
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    if (q > wmax) q = wmax;
    if (q < -wmax - 1) q = -wmax - 1;
    return q;
  endfunction

  function automatic los_t predict_los(target_t t);
    longint dx, dy, ah, av, c, vert, horiz;
    longint unsigned s00, s10;
    rmat_t pix, mnt, att, r;
    los_t o;
    dx  = longint'(t.pixel_x) - 8 * img_w;
    dy  = longint'(t.pixel_y) - 8 * img_h;
    ah  = los_atan2(dx, 16 * foc_h);
    av  = los_atan2(dy, 16 * foc_v);
    pix = euler_rot(0, ah, av);
    mnt = euler_rot(0, mnt_pitch <<< (30 - losa_pkg::ANGLE_FRAC_BITS), 0);
    att = euler_rot(longint'(t.roll) <<< (30 - losa_pkg::ANGLE_FRAC_BITS),
                    longint'(t.pitch) <<< (30 - losa_pkg::ANGLE_FRAC_BITS),
                    longint'(t.yaw) <<< (30 - losa_pkg::ANGLE_FRAC_BITS));
    r   = rot_mul(rot_mul(att, mnt), pix);
    s00 = longint'(r[0][0] * r[0][0]);
    s10 = longint'(r[1][0] * r[1][0]);
    c   = longint'(isqrt_u64(s00 + s10));
    o.lock = (r[0][0] == 0 && r[1][0] == 0);
    vert  = los_atan2(-r[2][0], c);
    horiz = o.lock ? los_atan2(-r[0][1], r[1][1]) : los_atan2(r[1][0], r[0][0]);
    o.horiz = 16'(quantize_angle(horiz, PI_Q, 16));
    o.vert  = 15'(quantize_angle(vert, HALF_PI_Q, 15));
    return o;
  endfunction

  // ---------------- drivers ----------------

  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_target(target_t t);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {t.yaw, t.pitch, t.roll, t.pixel_y, t.pixel_x};
    do @(posedge clk); while (!s_tready);
    expected_los.push_back(predict_los(t));
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      losa_pkg::CFG_IMAGE_WIDTH:      img_w = val[11:0];
      losa_pkg::CFG_IMAGE_HEIGHT:     img_h = val[11:0];
      losa_pkg::CFG_FOCAL_HORIZONTAL: foc_h = val[11:0];
      losa_pkg::CFG_FOCAL_VERTICAL:   foc_v = val[11:0];
      losa_pkg::CFG_MOUNT_PITCH:      mnt_pitch = longint'($signed(val));
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, let everything drain, then allow the pipeline to empty.
  task automatic drain_pipe();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_los.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_camera(int w, int h, int fh, int fv, int mp);
    drain_pipe();
    write_reg(losa_pkg::CFG_IMAGE_WIDTH, 16'(w));
    write_reg(losa_pkg::CFG_IMAGE_HEIGHT, 16'(h));
    write_reg(losa_pkg::CFG_FOCAL_HORIZONTAL, 16'(fh));
    write_reg(losa_pkg::CFG_FOCAL_VERTICAL, 16'(fv));
    write_reg(losa_pkg::CFG_MOUNT_PITCH, 16'(mp));
  endtask

  function automatic logic signed [15:0] rand_angle();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return 16'(ANG_MAX);
      1: return -16'(ANG_MAX);
      2: return 16'($urandom_range(0, 1) ? HALF_PI_FIX : -HALF_PI_FIX);
      default: return 16'($signed($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX);
    endcase
  endfunction

  function automatic target_t rand_target();
    target_t t;
    longint lim_x, lim_y;
    lim_x = (16 * img_w > 65535) ? 65535 : 16 * img_w;
    lim_y = (16 * img_h > 65535) ? 65535 : 16 * img_h;
    if ($urandom_range(0, 9) < 7) begin
      t.pixel_x = 16'($urandom_range(0, int'(lim_x)));
      t.pixel_y = 16'($urandom_range(0, int'(lim_y)));
    end else begin
      t.pixel_x = 16'($urandom);
      t.pixel_y = 16'($urandom);
    end
    t.roll  = rand_angle();
    t.pitch = rand_angle();
    t.yaw   = rand_angle();
    return t;
  endfunction

  // ---------------- receiver and checker ----------------

  initial begin
    int gap;
    int left;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        m_tready <= 1'b0;
        left = hold_req;
        hold_req = 0;
        while (left > 0) begin
          @(negedge clk);
          left--;
        end
      end
      gap = rx_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    los_t exp_o;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_los.size() == 0) begin
        failures++;
        if (mismatches++ < 10)
          $display("unexpected item: tdata=%h tuser=%b", m_tdata, m_tuser);
      end else begin
        exp_o = expected_los.pop_front();
        if (m_tdata[15:0] !== exp_o.horiz || m_tdata[30:16] !== exp_o.vert ||
            m_tuser !== exp_o.lock) begin
          failures++;
          if (mismatches++ < 10)
            $display("mismatch: horiz exp %0d got %0d, vert exp %0d got %0d, lock exp %b got %b",
                     exp_o.horiz, $signed(m_tdata[15:0]), exp_o.vert,
                     $signed(m_tdata[30:16]), exp_o.lock, m_tuser);
        end
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_reset_defaults();
    target_t t;
    t = '{16'd5120, 16'd3840, 16'sd0, 16'sd0, 16'sd0};   // image centre
    send_target(t);
    t = '{16'd0, 16'd0, 16'sd0, 16'sd0, 16'sd0};
    send_target(t);
    t = '{16'hFFFF, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0};
    send_target(t);
  endtask

  task automatic test_corner_targets();
    target_t t;
    // angle extremes and straight up/down pitch, where gimbal lock can appear
    t = '{16'd5120, 16'd3840, 16'(ANG_MAX), 16'(ANG_MAX), 16'(ANG_MAX)};   send_target(t);
    t = '{16'd5120, 16'd3840, -16'(ANG_MAX), -16'(ANG_MAX), -16'(ANG_MAX)}; send_target(t);
    t = '{16'd5120, 16'd3840, 16'sd0, 16'(HALF_PI_FIX), 16'sd0};          send_target(t);
    t = '{16'd5120, 16'd3840, 16'sd0, -16'(HALF_PI_FIX), 16'sd0};         send_target(t);
    t = '{16'hFFFF, 16'd0, 16'sd1000, -16'sd1000, 16'sd20000};           send_target(t);
    t = '{16'd0, 16'hFFFF, -16'sd1, 16'sd1, -16'sd20000};                send_target(t);
    t = '{16'h5555, 16'hAAAA, 16'sh1555, -16'sh1555, 16'sh2AAA};         send_target(t);
    drain_pipe();
    // mount straight down with a centred target
    set_camera(640, 480, 640, 480, HALF_PI_FIX);
    t = '{16'd5120, 16'd3840, 16'sd0, 16'sd0, 16'sd0};                   send_target(t);
    t = '{16'd5120, 16'd3840, 16'sd0, 16'(HALF_PI_FIX), 16'sd0};          send_target(t);
    t = '{16'd5120, 16'd3840, 16'(ANG_MAX), -16'(HALF_PI_FIX), 16'sd0};   send_target(t);
  endtask

  task automatic test_camera_extremes();
    target_t t;
    set_camera(1, 1, 1, 1, -ANG_MAX);
    t = '{16'd8, 16'd8, 16'sd0, 16'sd0, 16'sd0};     send_target(t);
    t = '{16'hFFFF, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0}; send_target(t);
    repeat (20) send_target(rand_target());
    set_camera(4095, 4095, 4095, 4095, ANG_MAX);
    t = '{16'd0, 16'd0, 16'sd0, 16'sd0, 16'sd0};     send_target(t);
    t = '{16'hFFFF, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0}; send_target(t);
    repeat (20) send_target(rand_target());
    // zero focal length and zero image size are taken as written
    set_camera(0, 0, 0, 0, 0);
    t = '{16'd0, 16'd0, 16'sd0, 16'sd0, 16'sd0};     send_target(t);
    t = '{16'd100, 16'd0, 16'sd0, 16'sd0, 16'sd0};   send_target(t);
    repeat (10) send_target(rand_target());
    // writes beyond the register list must leave the setting unchanged
    drain_pipe();
    write_reg(CFG_UNUSED_LO, 16'hFFFF);
    write_reg(CFG_UNUSED_HI, 16'h1234);
    repeat (10) send_target(rand_target());
  endtask

  task automatic test_random_targets();
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) set_camera(640, 480, 640, 480, -2145);
      else set_camera($urandom_range(1, 4095), $urandom_range(1, 4095),
                      $urandom_range(1, 4095), $urandom_range(1, 4095),
                      $urandom_range(0, 2 * ANG_MAX) - ANG_MAX);
      for (int n = 0; n < 200; n++) begin
        if (n % 50 == 0) begin
          tx_burst = ($urandom_range(0, 3) == 0);
          rx_burst = ($urandom_range(0, 3) == 0);
        end
        send_target(rand_target());
      end
    end
    tx_burst = 0;
    rx_burst = 0;
  endtask

  task automatic test_output_hold();
    tx_burst = 1;
    hold_req = 400;
    repeat (200) send_target(rand_target());
    tx_burst = 0;
  endtask

  initial begin
    img_w = 640; img_h = 480; foc_h = 640; foc_v = 480; mnt_pitch = -2145;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_corner_targets();
    test_camera_extremes();
    test_random_targets();
    test_output_hold();
    drain_pipe();
    if (expected_los.size() != 0) failures++;
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
sv/losa_pkg.sv
sv/losa_sincos.sv
sv/losa_atan2.sv
sv/losa_euler.sv
sv/line_of_sight_angle_calc.sv
tb/sv/tb_top.sv
